### rtl/apcm_pkg.sv
// Package with the shared types and codes of the adaptive palette color mapper.
`default_nettype none
package apcm_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_NEAR,
        ST_LOOK,
        ST_LOOK_DATA
    } state_t;

    typedef logic [2:0] outcome_t;
    typedef logic [1:0] cfg_index_t;

    // Result outcome codes.
    localparam outcome_t OUT_MATCH   = 3'd0;
    localparam outcome_t OUT_ALLOC   = 3'd1;
    localparam outcome_t OUT_NEAREST = 3'd2;
    localparam outcome_t OUT_HIT     = 3'd3;
    localparam outcome_t OUT_MISS    = 3'd4;

    // Configuration register indexes.
    localparam cfg_index_t CFG_TOLERANCE = 2'd0;
    localparam cfg_index_t CFG_RESERVED  = 2'd1;
    localparam cfg_index_t CFG_USABLE    = 2'd2;

    // Request codes.
    localparam logic OP_MAP    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Field widths and reset values.
    localparam int CHAN_W = 8;
    localparam int IDX_W  = 11;
    localparam int TOL_W  = 8;
    localparam int RSV_W  = 10;
    localparam int USE_W  = 11;
    localparam int CFG_W  = 11;

    localparam logic [TOL_W-1:0] TOL_RESET = 8'd8;
    localparam logic [RSV_W-1:0] RSV_RESET = 10'd16;
    localparam logic [USE_W-1:0] USE_RESET = 11'd1008;

    // Sums of channel differences must stay below this to count as nearest.
    localparam logic [8:0] NEAR_LIMIT = 9'd256;

    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

### rtl/adaptive_palette_color_mapper.sv
// Top level of the adaptive palette color mapper: sequencer, palette memory and output register.
// A lookup reads the addressed entry unless it misses; a map sweeps the filled entries, stops at
// the lowest tolerance match, else allocates the next free entry if there is room.
// Map when full: two sweeps over the single read port, the second for the nearest entry.
// One request at a time: the next is taken in the cycle after the result loads.
// Reset: asynchronous, active low; registers to 8 / 16 / 1008, fill to 0, memory left undefined.
`default_nettype none
module adaptive_palette_color_mapper
    import apcm_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              op,
    input  wire logic [CHAN_W-1:0] red_in,
    input  wire logic [CHAN_W-1:0] green_in,
    input  wire logic [CHAN_W-1:0] blue_in,
    input  wire logic [IDX_W-1:0]  index_in,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [IDX_W-1:0]       color_index,
    output logic [2:0]             outcome,
    output logic [CHAN_W-1:0]      red_out,
    output logic [CHAN_W-1:0]      green_out,
    output logic [CHAN_W-1:0]      blue_out
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    // Configuration registers.
    logic [TOL_W-1:0] tol_reg;
    logic [RSV_W-1:0] rsv_reg;
    logic [USE_W-1:0] use_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
            rsv_reg <= RSV_RESET;
            use_reg <= USE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TOLERANCE: tol_reg <= cfg_data[TOL_W-1:0];
                CFG_RESERVED:  rsv_reg <= cfg_data[RSV_W-1:0];
                CFG_USABLE:    use_reg <= cfg_data[USE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Control state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pidx_reg, pidx_next;
    logic [ADDR_W-1:0] best_reg, best_next;
    logic [8:0]        min_reg, min_next;
    logic              out_valid_reg, out_valid_next;

    // Request payload.
    logic [CHAN_W-1:0] r_reg, g_reg, b_reg;
    logic [IDX_W-1:0]  idx_reg;

    // Output payload.
    logic [IDX_W-1:0]  cidx_reg, cidx_next;
    outcome_t          oc_reg, oc_next;
    logic [CHAN_W-1:0] ro_reg, ro_next;
    logic [CHAN_W-1:0] go_reg, go_next;
    logic [CHAN_W-1:0] bo_reg, bo_next;
    logic              load_out;

    // Palette memory port.
    logic [23:0]       mem [TABLE_DEPTH];
    logic [23:0]       rd_data_reg;
    logic              mem_re, mem_we;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;

    // Shared difference unit on the entry that was just read.
    logic [CHAN_W-1:0] dr, dg, db;
    logic              tol_match;
    logic [9:0]        dist_sum;

    assign dr = absdiff(r_reg, rd_data_reg[23:16]);
    assign dg = absdiff(g_reg, rd_data_reg[15:8]);
    assign db = absdiff(b_reg, rd_data_reg[7:0]);
    assign tol_match = (dr < tol_reg) && (dg < tol_reg) && (db < tol_reg);
    assign dist_sum = 10'(dr) + 10'(dg) + 10'(db);

    logic              can_out;
    logic              sweep_more;
    logic              room;
    logic              look_hit;
    logic [IDX_W-1:0]  look_diff;

    assign can_out    = !out_valid_reg || out_ready;
    assign sweep_more = addr_reg < fill_reg;
    assign room       = (CMP_W'(fill_reg) < CMP_W'(use_reg)) && (fill_reg < DEPTH_C);
    assign look_diff  = idx_reg - IDX_W'(rsv_reg);
    assign look_hit   = (idx_reg >= IDX_W'(rsv_reg)) && (CMP_W'(look_diff) < CMP_W'(fill_reg));

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        pidx_next      = pidx_reg;
        best_next      = best_reg;
        min_next       = min_reg;
        out_valid_next = out_valid_reg && !out_ready;
        load_out       = 1'b0;
        cidx_next      = cidx_reg;
        oc_next        = oc_reg;
        ro_next        = ro_reg;
        go_next        = go_reg;
        bo_next        = bo_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_raddr      = addr_reg[ADDR_W-1:0];
        mem_waddr      = fill_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next  = '0;
                    pend_next  = 1'b0;
                    state_next = (op == OP_LOOKUP) ? ST_LOOK : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (pend_reg && tol_match)
                begin
                    // Lowest matching entry wins; hold the sweep until the output is free.
                    if (can_out)
                    begin
                        load_out   = 1'b1;
                        cidx_next  = IDX_W'(pidx_reg) + IDX_W'(rsv_reg);
                        oc_next    = OUT_MATCH;
                        ro_next    = '0;
                        go_next    = '0;
                        bo_next    = '0;
                        state_next = ST_IDLE;
                    end
                end
                else if (sweep_more)
                begin
                    mem_re    = 1'b1;
                    pidx_next = addr_reg[ADDR_W-1:0];
                    addr_next = addr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else if (room)
                begin
                    if (can_out)
                    begin
                        mem_we     = 1'b1;
                        fill_next  = fill_reg + 1'b1;
                        load_out   = 1'b1;
                        cidx_next  = IDX_W'(fill_reg[ADDR_W-1:0]) + IDX_W'(rsv_reg);
                        oc_next    = OUT_ALLOC;
                        ro_next    = r_reg;
                        go_next    = g_reg;
                        bo_next    = b_reg;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    addr_next  = '0;
                    pend_next  = 1'b0;
                    best_next  = '0;
                    min_next   = NEAR_LIMIT;
                    state_next = ST_NEAR;
                end
            end

            ST_NEAR:
            begin
                if (pend_reg && (dist_sum < 10'(min_reg)))
                begin
                    min_next  = dist_sum[8:0];
                    best_next = pidx_reg;
                end
                if (sweep_more)
                begin
                    mem_re    = 1'b1;
                    pidx_next = addr_reg[ADDR_W-1:0];
                    addr_next = addr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else if (can_out)
                begin
                    load_out   = 1'b1;
                    cidx_next  = IDX_W'(best_reg) + IDX_W'(rsv_reg);
                    oc_next    = OUT_NEAREST;
                    ro_next    = '0;
                    go_next    = '0;
                    bo_next    = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_LOOK:
            begin
                if (look_hit)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(look_diff);
                    state_next = ST_LOOK_DATA;
                end
                else if (can_out)
                begin
                    load_out   = 1'b1;
                    cidx_next  = '0;
                    oc_next    = OUT_MISS;
                    ro_next    = '0;
                    go_next    = '0;
                    bo_next    = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_LOOK_DATA:
            begin
                if (can_out)
                begin
                    load_out   = 1'b1;
                    cidx_next  = '0;
                    oc_next    = OUT_HIT;
                    ro_next    = rd_data_reg[23:16];
                    go_next    = rd_data_reg[15:8];
                    bo_next    = rd_data_reg[7:0];
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        best_reg <= best_next;
        min_reg  <= min_next;
        cidx_reg <= cidx_next;
        oc_reg   <= oc_next;
        ro_reg   <= ro_next;
        go_reg   <= go_next;
        bo_reg   <= bo_next;
        if (in_valid && in_ready)
        begin
            r_reg   <= red_in;
            g_reg   <= green_in;
            b_reg   <= blue_in;
            idx_reg <= index_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= {r_reg, g_reg, b_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign color_index = cidx_reg;
    assign outcome     = oc_reg;
    assign red_out     = ro_reg;
    assign green_out   = go_reg;
    assign blue_out    = bo_reg;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != ST_IDLE)
        else $error("accepted transaction did not start the sequencer");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("fill count exceeds palette depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> can_out)
        else $error("result loaded while previous result still waits");

    a_fill_only_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != $past(fill_reg) |-> $past(mem_we) && oc_reg == OUT_ALLOC)
        else $error("fill count changed without an allocation");
`endif

endmodule
`default_nettype wire
